// ----- hw/rtl/wrapped_angle_interp_lookup_top_macros.svh -----
// assertion macros used by the top level rtl file
`ifndef WRAPPED_ANGLE_INTERP_LOOKUP_TOP_MACROS_SVH
`define WRAPPED_ANGLE_INTERP_LOOKUP_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define WALI_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wali check failed");
`define WALI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wali check failed");
`else
`define WALI_ASSERT_IMP(label, ante, cons)
`define WALI_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ----- hw/rtl/wali_pkg.sv -----
// shared constants for the wrapped angle lookup block
`timescale 1ns / 1ps
package wali_pkg;

  localparam int ADDR_W = 9;

  localparam logic [ADDR_W-1:0] DEG_COUNT = 9'd360;
  localparam logic [ADDR_W-1:0] LAST_DEG  = 9'd359;
  localparam logic [ADDR_W-1:0] FIRST_DEG = 9'd0;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [1:0] TBL_LIFT   = 2'd0;
  localparam logic [1:0] TBL_DRAG   = 2'd1;
  localparam logic [1:0] TBL_MOMENT = 2'd2;

endpackage

// ----- hw/rtl/wrapped_angle_interp_lookup_top.sv -----
// top level of the wrapped angle interpolated coefficient lookup
`timescale 1ns / 1ps
`include "wrapped_angle_interp_lookup_top_macros.svh"
// Usage
// One input channel (in_valid / in_stall) carries two kinds of item. A write item
// (opcode 0) stores entry_value at entry_index of the table chosen by table_select
// and gives no result; indexes past 359 and table select 3 are dropped. A query item
// (opcode 1) gives a signed angle with FRAC_BITS fraction bits; it is wrapped into
// 0..360 degrees, the entries at the whole degree and the next one (359 wraps to 0)
// are blended by the fraction, and one result item with lift, drag and moment comes
// out on the output channel (out_valid / out_stall). Lift is negated, saturating,
// for wrapped angles strictly between 90 and 270 degrees.
// Throughput is one item per cycle while out_stall is low, since
// each table is a dual read port ram and both entries of a query come in one read.
// Write and read both happen as an item leaves the first stage, so items stay in order.
// Reset clears the pipeline valids only; the tables are undefined until written and
// must be loaded before they are queried. When out_stall holds, the result stays and
// the stages behind it keep filling; in_stall rises only once every stage is full.
module wrapped_angle_interp_lookup_top #(
  parameter int COEF_BITS = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        opcode,
  input  logic signed [FRAC_BITS+10:0] angle,
  input  logic        [1:0]           table_select,
  input  logic        [8:0]           entry_index,
  input  logic signed [COEF_BITS-1:0] entry_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [COEF_BITS-1:0] lift,
  output logic signed [COEF_BITS-1:0] drag,
  output logic signed [COEF_BITS-1:0] moment
);

  import wali_pkg::*;

  localparam int ANGLE_W = FRAC_BITS + 11;
  localparam int EXT_W   = ANGLE_W + 2;
  localparam int W_W     = FRAC_BITS + 9;

  localparam logic signed [EXT_W-1:0] P360  = EXT_W'(360 * (2 ** FRAC_BITS));
  localparam logic signed [EXT_W-1:0] P720  = EXT_W'(720 * (2 ** FRAC_BITS));
  localparam logic signed [EXT_W-1:0] P1080 = EXT_W'(1080 * (2 ** FRAC_BITS));

  localparam logic [W_W-1:0] ANG_90     = W_W'(90 * (2 ** FRAC_BITS));
  localparam logic [W_W-1:0] ANG_270    = W_W'(270 * (2 ** FRAC_BITS));
  localparam logic [W_W-1:0] ANG_PERIOD = W_W'(360 * (2 ** FRAC_BITS));

  localparam logic signed [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};
  localparam logic signed [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};

  // stage enables
  logic en1, en2, en3, en_out;

  // wrap
  logic signed [EXT_W-1:0] angle_ext;
  logic signed [EXT_W-1:0] wrap_off;
  logic signed [EXT_W-1:0] wrap_sum;

  // stage 1
  logic                        s1_valid;
  logic                        s1_op;
  logic [W_W-1:0]              s1_w;
  logic [1:0]                  s1_sel;
  logic [ADDR_W-1:0]           s1_idx;
  logic signed [COEF_BITS-1:0] s1_val;

  logic [ADDR_W-1:0]    rd_i1;
  logic [ADDR_W-1:0]    rd_i2;
  logic [FRAC_BITS-1:0] s1_frac;
  logic                 s1_neg;
  logic                 wr_go;
  logic                 lift_we, drag_we, moment_we;

  // stage 2
  logic                 s2_valid;
  logic [FRAC_BITS-1:0] s2_frac;
  logic                 s2_neg;
  logic signed [COEF_BITS-1:0] lift_c1, lift_c2, drag_c1, drag_c2, moment_c1, moment_c2;

  // stage 3
  logic                        s3_valid;
  logic                        s3_neg;
  logic signed [COEF_BITS-1:0] lift_b, drag_b, moment_b;
  logic signed [COEF_BITS-1:0] lift_next;

  assign en_out   = !out_valid || !out_stall;
  assign en3      = !s3_valid || en_out;
  assign en2      = !s2_valid || en3;
  assign en1      = !s1_valid || en2;
  assign in_stall = !en1;

  // one add brings any angle of the input range into 0..360
  always_comb begin
    angle_ext = EXT_W'(angle);
    priority if (angle_ext >= P720) begin
      wrap_off = -P720;
    end else if (angle_ext >= P360) begin
      wrap_off = -P360;
    end else if (!angle_ext[EXT_W-1]) begin
      wrap_off = '0;
    end else if (angle_ext >= -P360) begin
      wrap_off = P360;
    end else if (angle_ext >= -P720) begin
      wrap_off = P720;
    end else begin
      wrap_off = P1080;
    end
    wrap_sum = angle_ext + wrap_off;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en1) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      s1_op  <= opcode;
      s1_w   <= wrap_sum[W_W-1:0];
      s1_sel <= table_select;
      s1_idx <= entry_index;
      s1_val <= entry_value;
    end
  end

  always_comb begin
    rd_i1   = s1_w[W_W-1:FRAC_BITS];
    rd_i2   = (rd_i1 == LAST_DEG) ? FIRST_DEG : rd_i1 + 1'b1;
    s1_frac = s1_w[FRAC_BITS-1:0];
    s1_neg  = (s1_w > ANG_90) && (s1_w < ANG_270);
    wr_go   = s1_valid && (s1_op == OP_WRITE) && en2 && (s1_idx < DEG_COUNT);
    lift_we   = wr_go && (s1_sel == TBL_LIFT);
    drag_we   = wr_go && (s1_sel == TBL_DRAG);
    moment_we = wr_go && (s1_sel == TBL_MOMENT);
  end

  wali_ram #(.WIDTH(COEF_BITS), .DEPTH(360)) u_lift_ram (
    .clk(clk), .we(lift_we), .waddr(s1_idx), .wdata(s1_val), .re(en2),
    .raddr_a(rd_i1), .raddr_b(rd_i2), .rdata_a(lift_c1), .rdata_b(lift_c2)
  );

  wali_ram #(.WIDTH(COEF_BITS), .DEPTH(360)) u_drag_ram (
    .clk(clk), .we(drag_we), .waddr(s1_idx), .wdata(s1_val), .re(en2),
    .raddr_a(rd_i1), .raddr_b(rd_i2), .rdata_a(drag_c1), .rdata_b(drag_c2)
  );

  wali_ram #(.WIDTH(COEF_BITS), .DEPTH(360)) u_moment_ram (
    .clk(clk), .we(moment_we), .waddr(s1_idx), .wdata(s1_val), .re(en2),
    .raddr_a(rd_i1), .raddr_b(rd_i2), .rdata_a(moment_c1), .rdata_b(moment_c2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (en2) begin
      s2_valid <= s1_valid && (s1_op == OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      s2_frac <= s1_frac;
      s2_neg  <= s1_neg;
    end
  end

  wali_blend #(.COEF_BITS(COEF_BITS), .FRAC_BITS(FRAC_BITS)) u_lift_blend (
    .clk(clk), .en(en3), .c1(lift_c1), .c2(lift_c2), .frac(s2_frac), .value(lift_b)
  );

  wali_blend #(.COEF_BITS(COEF_BITS), .FRAC_BITS(FRAC_BITS)) u_drag_blend (
    .clk(clk), .en(en3), .c1(drag_c1), .c2(drag_c2), .frac(s2_frac), .value(drag_b)
  );

  wali_blend #(.COEF_BITS(COEF_BITS), .FRAC_BITS(FRAC_BITS)) u_moment_blend (
    .clk(clk), .en(en3), .c1(moment_c1), .c2(moment_c2), .frac(s2_frac),
    .value(moment_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (en3) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      s3_neg <= s2_neg;
    end
  end

  // saturating negate for the rear half of the circle
  always_comb begin
    if (!s3_neg) begin
      lift_next = lift_b;
    end else if (lift_b == COEF_MIN) begin
      lift_next = COEF_MAX;
    end else begin
      lift_next = -lift_b;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en_out) begin
      out_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      lift   <= lift_next;
      drag   <= drag_b;
      moment <= moment_b;
    end
  end

  `WALI_ASSERT_IMP(a_stall_only_when_full, in_stall, s1_valid && s2_valid && s3_valid && out_valid && out_stall)
  `WALI_ASSERT_IMP(a_wrap_in_range, s1_valid && (s1_op == OP_QUERY), s1_w < ANG_PERIOD)
  `WALI_ASSERT_NEXT(a_query_enters, in_valid && !in_stall && (opcode == OP_QUERY), s1_valid && (s1_op == OP_QUERY))
  `WALI_ASSERT_NEXT(a_result_kept, out_valid && out_stall, out_valid && $stable(lift) && $stable(moment))

endmodule

// ----- hw/rtl/wali_ram.sv -----
// generic ram, one write port and two registered read ports
`timescale 1ns / 1ps
module wali_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 360
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// ----- hw/rtl/wali_blend.sv -----
// linear blend of two adjacent coefficients, registered product stage
`timescale 1ns / 1ps
module wali_blend #(
  parameter int COEF_BITS = 16,
  parameter int FRAC_BITS = 8
) (
  input  logic                        clk,
  input  logic                        en,
  input  logic signed [COEF_BITS-1:0] c1,
  input  logic signed [COEF_BITS-1:0] c2,
  input  logic        [FRAC_BITS-1:0] frac,
  output logic signed [COEF_BITS-1:0] value
);

  localparam int PROD_W = COEF_BITS + FRAC_BITS + 2;

  logic signed [COEF_BITS:0]   diff;
  logic signed [FRAC_BITS:0]   frac_s;
  logic signed [PROD_W-1:0]    prod_next;
  logic signed [PROD_W-1:0]    prod;
  logic signed [COEF_BITS-1:0] base;
  logic signed [PROD_W-1:0]    shifted;

  always_comb begin
    diff      = (COEF_BITS+1)'(c2) - (COEF_BITS+1)'(c1);
    frac_s    = $signed({1'b0, frac});
    prod_next = PROD_W'(diff) * PROD_W'(frac_s);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
      base <= c1;
    end
  end

  // floor shift, result always lies between the two entries
  assign shifted = prod >>> FRAC_BITS;
  assign value   = base + shifted[COEF_BITS-1:0];

endmodule
